[design/tpb_pkg.sv]
// Shared types and constants of the tree preorder builder.
package tpb_pkg;

  localparam int unsigned MaxJoints = 256;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned CntW      = 9;
  localparam int unsigned ParW      = 10;
  localparam int unsigned IdW       = 32;
  localparam int unsigned FrameW    = IdxW + CntW + IdxW;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [ParW-1:0] PARENT_NONE = '1;

  localparam logic REG_BUILD_LEVELS = 1'b0;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OUT_OF_RANGE = 3'd1,
    ST_OWN_PARENT   = 3'd2,
    ST_CYCLE        = 3'd3,
    ST_TOO_MANY     = 3'd4,
    ST_BAD_POSITION = 3'd5
  } status_e;

endpackage

[design/tpb_if.sv]
// Word channels of the tree preorder builder.
interface tpb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] joint_id;
  logic [9:0]  parent_index;
  logic        last_joint;
  logic [7:0]  read_position;
  modport source (output valid, command, joint_id, parent_index, last_joint, read_position,
                  input ready);
  modport sink (input valid, command, joint_id, parent_index, last_joint, read_position,
                output ready);
endinterface

interface tpb_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  status;
  logic [8:0]  joint_total;
  logic [31:0] entry_id;
  logic [31:0] parent_id;
  logic [7:0]  depth;
  logic [7:0]  span_start;
  logic [8:0]  span_stop;
  logic [7:0]  level_slot;
  logic [8:0]  level_total;
  modport source (output valid, result_kind, status, joint_total, entry_id, parent_id, depth,
                  span_start, span_stop, level_slot, level_total, input ready);
  modport sink (input valid, result_kind, status, joint_total, entry_id, parent_id, depth,
                span_start, span_stop, level_slot, level_total, output ready);
endinterface

[design/tpb_cfg.sv]
// APB register file holding the build_levels control bit.
module tpb_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        build_levels_o
);

  logic levels_q, levels_d;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tpb_pkg::REG_BUILD_LEVELS);

  always_comb begin
    levels_d = levels_q;
    if (psel && penable && pwrite && reg_hit) begin
      levels_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= 1'b1;
    end else begin
      levels_q <= levels_d;
    end
  end

  assign prdata         = reg_hit ? {31'd0, levels_q} : 32'd0;
  assign build_levels_o = levels_q;

endmodule

[design/tpb_engine.sv]
// Load, build and read sequencer with the joint and layout memories.
module tpb_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        build_levels_i,
  tpb_in_if.sink      in_i,
  tpb_out_if.source   out_o
);

  localparam int unsigned IW = tpb_pkg::IdxW;
  localparam int unsigned CW = tpb_pkg::CntW;
  localparam int unsigned PW = tpb_pkg::ParW;
  localparam int unsigned DW = tpb_pkg::IdW;
  localparam int unsigned FW = tpb_pkg::FrameW;
  localparam int unsigned D  = tpb_pkg::MaxJoints;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CHK_RD  = 16'h0002,
    S_CHK_EV  = 16'h0004,
    S_ROOT_RD = 16'h0008,
    S_ROOT_EV = 16'h0010,
    S_SCAN_RD = 16'h0020,
    S_SCAN_EV = 16'h0040,
    S_POP     = 16'h0080,
    S_FIN     = 16'h0100,
    S_LVL_RD  = 16'h0200,
    S_LVL_EV  = 16'h0400,
    S_RD2     = 16'h0800,
    S_RD3     = 16'h1000,
    S_RD4     = 16'h2000,
    S_OUT     = 16'h4000,
    S_SPARE   = 16'h8000
  } state_e;

  logic [DW-1:0] id_mem   [D];
  logic [PW-1:0] par_mem  [D];
  logic [IW-1:0] jop_mem  [D];
  logic [IW-1:0] dep_mem  [D];
  logic [CW-1:0] end_mem  [D];
  logic [IW-1:0] slot_mem [D];
  logic [FW-1:0] stk_mem  [D];

  logic          id_we, par_we, jop_we, dep_we, end_we, slot_we, stk_we;
  logic [IW-1:0] id_wa, par_wa, jop_wa, dep_wa, end_wa, slot_wa, stk_wa;
  logic [DW-1:0] id_wd;
  logic [PW-1:0] par_wd;
  logic [IW-1:0] jop_wd, dep_wd, slot_wd;
  logic [CW-1:0] end_wd;
  logic [FW-1:0] stk_wd;
  logic [IW-1:0] id_ra, par_ra, pos_ra, dep_ra, stk_ra;
  logic [DW-1:0] id_rd;
  logic [PW-1:0] par_rd;
  logic [IW-1:0] jop_rd, dep_rd, slot_rd;
  logic [CW-1:0] end_rd;
  logic [FW-1:0] stk_rd;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d, closed_q, closed_d, valid_q, valid_d;
  logic [CW-1:0] ltot_q, ltot_d;
  logic [CW-1:0] i_q, i_d, pos_q, pos_d, sp_q, sp_d, tn_q, tn_d;
  logic [IW-1:0] tj_q, tj_d, tp_q, tp_d, maxd_q, maxd_d, lvl_q, lvl_d, slot_q, slot_d;
  logic [IW-1:0] rpos_q, rpos_d;

  logic          rk_q, rk_d;
  logic [2:0]    rst_q, rst_d;
  logic [DW-1:0] rent_q, rent_d, rpid_q, rpid_d;
  logic [IW-1:0] rdep_q, rdep_d, rslot_q, rslot_d, rbeg_q, rbeg_d;
  logic [CW-1:0] rend_q, rend_d, rtot_q, rtot_d, rlt_q, rlt_d;

  logic          ov_q, ov_d;
  logic          ok_q;
  logic [2:0]    os_q;
  logic [CW-1:0] otot_q, oend_q, olt_q;
  logic [DW-1:0] oent_q, opid_q;
  logic [IW-1:0] odep_q, obeg_q, oslot_q;

  logic          in_acc, out_free, fin;
  logic [2:0]    fin_st;
  logic [CW-1:0] fin_lt, cnt_eff;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (id_we) id_mem[id_wa] <= id_wd;
    id_rd <= id_mem[id_ra];
  end
  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[par_ra];
  end
  always_ff @(posedge clk_i) begin
    if (jop_we) jop_mem[jop_wa] <= jop_wd;
    jop_rd <= jop_mem[pos_ra];
  end
  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    dep_rd <= dep_mem[dep_ra];
  end
  always_ff @(posedge clk_i) begin
    if (end_we) end_mem[end_wa] <= end_wd;
    end_rd <= end_mem[pos_ra];
  end
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[pos_ra];
  end
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ovf_d = ovf_q; closed_d = closed_q; valid_d = valid_q; ltot_d = ltot_q;
    i_d = i_q; pos_d = pos_q; sp_d = sp_q; tn_d = tn_q; tj_d = tj_q; tp_d = tp_q;
    maxd_d = maxd_q; lvl_d = lvl_q; slot_d = slot_q; rpos_d = rpos_q;
    rk_d = rk_q; rst_d = rst_q; rent_d = rent_q; rpid_d = rpid_q; rdep_d = rdep_q;
    rslot_d = rslot_q; rbeg_d = rbeg_q; rend_d = rend_q; rtot_d = rtot_q; rlt_d = rlt_q;
    id_we = 1'b0; par_we = 1'b0; jop_we = 1'b0; dep_we = 1'b0;
    end_we = 1'b0; slot_we = 1'b0; stk_we = 1'b0;
    id_wa = '0; par_wa = '0; jop_wa = pos_q[IW-1:0]; dep_wa = pos_q[IW-1:0];
    end_wa = tp_q; slot_wa = i_q[IW-1:0]; stk_wa = '0;
    id_wd = in_i.joint_id; par_wd = in_i.parent_index; jop_wd = '0; dep_wd = '0;
    end_wd = pos_q; slot_wd = slot_q; stk_wd = '0;
    id_ra = '0; par_ra = '0; pos_ra = in_i.read_position; dep_ra = in_i.read_position;
    stk_ra = '0;
    fin = 1'b0; fin_st = tpb_pkg::ST_OK; fin_lt = '0;
    cnt_eff = closed_q ? '0 : cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.command == tpb_pkg::CMD_LOAD) begin
          if (closed_q) begin
            ovf_d   = 1'b0;
            valid_d = 1'b0;
          end
          closed_d = in_i.last_joint;
          if (!cnt_eff[CW-1]) begin
            id_we  = 1'b1;
            par_we = 1'b1;
            id_wa  = cnt_eff[IW-1:0];
            par_wa = cnt_eff[IW-1:0];
            cnt_d  = cnt_eff + 1'b1;
          end else begin
            cnt_d = cnt_eff;
            ovf_d = 1'b1;
          end
          if (in_i.last_joint) begin
            valid_d = 1'b0;
            if (ovf_d) begin
              fin    = 1'b1;
              fin_st = tpb_pkg::ST_TOO_MANY;
            end else begin
              i_d     = '0;
              state_d = S_CHK_RD;
            end
          end
        end else if (in_acc) begin
          rk_d = tpb_pkg::KIND_READ; rtot_d = cnt_q;
          rent_d = '0; rpid_d = '0; rdep_d = '0; rbeg_d = '0; rend_d = '0;
          rslot_d = '0; rlt_d = '0;
          if (!valid_q || {1'b0, in_i.read_position} >= cnt_q) begin
            rst_d   = tpb_pkg::ST_BAD_POSITION;
            state_d = S_OUT;
          end else begin
            rst_d   = tpb_pkg::ST_OK;
            rpos_d  = in_i.read_position;
            state_d = S_RD2;
          end
        end
      end
      S_CHK_RD: begin
        par_ra  = i_q[IW-1:0];
        state_d = S_CHK_EV;
      end
      S_CHK_EV: begin
        if ((par_rd[PW-1] && par_rd != tpb_pkg::PARENT_NONE) ||
            (!par_rd[PW-1] && par_rd[CW-1:0] >= cnt_q)) begin
          fin    = 1'b1;
          fin_st = tpb_pkg::ST_OUT_OF_RANGE;
        end else if (!par_rd[PW-1] && par_rd[CW-1:0] == i_q) begin
          fin    = 1'b1;
          fin_st = tpb_pkg::ST_OWN_PARENT;
        end else if (i_q + 1'b1 == cnt_q) begin
          i_d = '0; pos_d = '0; maxd_d = '0;
          state_d = S_ROOT_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_CHK_RD;
        end
      end
      S_ROOT_RD: begin
        if (i_q == cnt_q) begin
          state_d = S_FIN;
        end else begin
          par_ra  = i_q[IW-1:0];
          state_d = S_ROOT_EV;
        end
      end
      S_ROOT_EV: begin
        if (par_rd == tpb_pkg::PARENT_NONE) begin
          jop_we = 1'b1; jop_wd = i_q[IW-1:0];
          dep_we = 1'b1; dep_wd = '0;
          tj_d = i_q[IW-1:0]; tn_d = '0; tp_d = pos_q[IW-1:0];
          sp_d = 9'd1; pos_d = pos_q + 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_ROOT_RD;
        end
      end
      S_SCAN_RD: begin
        if (tn_q == cnt_q) begin
          end_we = 1'b1;
          sp_d   = sp_q - 1'b1;
          if (sp_q == 9'd1) begin
            i_d     = i_q + 1'b1;
            state_d = S_ROOT_RD;
          end else begin
            stk_ra  = sp_q[IW-1:0] - 8'd2;
            state_d = S_POP;
          end
        end else begin
          par_ra  = tn_q[IW-1:0];
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (!par_rd[PW-1] && par_rd[CW-1:0] == {1'b0, tj_q}) begin
          stk_we = 1'b1;
          stk_wa = sp_q[IW-1:0] - 8'd1;
          stk_wd = {tj_q, tn_q + 1'b1, tp_q};
          jop_we = 1'b1; jop_wd = tn_q[IW-1:0];
          dep_we = 1'b1; dep_wd = sp_q[IW-1:0];
          if (sp_q[IW-1:0] > maxd_q) maxd_d = sp_q[IW-1:0];
          tj_d = tn_q[IW-1:0]; tn_d = '0; tp_d = pos_q[IW-1:0];
          pos_d = pos_q + 1'b1; sp_d = sp_q + 1'b1;
        end else begin
          tn_d = tn_q + 1'b1;
        end
        state_d = S_SCAN_RD;
      end
      S_POP: begin
        {tj_d, tn_d, tp_d} = stk_rd;
        state_d = S_SCAN_RD;
      end
      S_FIN: begin
        if (pos_q != cnt_q) begin
          fin    = 1'b1;
          fin_st = tpb_pkg::ST_CYCLE;
        end else if (build_levels_i) begin
          i_d = '0; lvl_d = '0; slot_d = '0;
          state_d = S_LVL_RD;
        end else begin
          fin = 1'b1;
        end
      end
      S_LVL_RD: begin
        if (i_q == cnt_q) begin
          if (lvl_q == maxd_q) begin
            fin    = 1'b1;
            fin_lt = {1'b0, maxd_q} + 1'b1;
          end else begin
            lvl_d = lvl_q + 1'b1;
            i_d   = '0;
          end
        end else begin
          dep_ra  = i_q[IW-1:0];
          state_d = S_LVL_EV;
        end
      end
      S_LVL_EV: begin
        if (dep_rd == lvl_q) begin
          slot_we = 1'b1;
          slot_d  = slot_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = S_LVL_RD;
      end
      S_RD2: begin
        id_ra = jop_rd; par_ra = jop_rd;
        rdep_d = dep_rd; rend_d = end_rd; rbeg_d = rpos_q;
        rslot_d = (ltot_q != '0) ? slot_rd : '0;
        rlt_d = ltot_q;
        state_d = S_RD3;
      end
      S_RD3: begin
        rent_d = id_rd;
        if (!par_rd[PW-1]) begin
          id_ra   = par_rd[IW-1:0];
          state_d = S_RD4;
        end else begin
          rpid_d  = '0;
          state_d = S_OUT;
        end
      end
      S_RD4: begin
        rpid_d  = id_rd;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      rk_d = tpb_pkg::KIND_BUILD; rst_d = fin_st; rtot_d = cnt_d;
      rent_d = '0; rpid_d = '0; rdep_d = '0; rbeg_d = '0; rend_d = '0; rslot_d = '0;
      valid_d = (fin_st == tpb_pkg::ST_OK);
      ltot_d  = fin_lt;
      rlt_d   = fin_lt;
      state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; ovf_q <= 1'b0; closed_q <= 1'b0; valid_q <= 1'b0; ltot_q <= '0;
      i_q <= '0; pos_q <= '0; sp_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; ovf_q <= ovf_d; closed_q <= closed_d; valid_q <= valid_d;
      ltot_q <= ltot_d; i_q <= i_d; pos_q <= pos_d; sp_q <= sp_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tn_q <= tn_d; tj_q <= tj_d; tp_q <= tp_d; maxd_q <= maxd_d; lvl_q <= lvl_d;
    slot_q <= slot_d; rpos_q <= rpos_d;
    rk_q <= rk_d; rst_q <= rst_d; rent_q <= rent_d; rpid_q <= rpid_d; rdep_q <= rdep_d;
    rslot_q <= rslot_d; rbeg_q <= rbeg_d; rend_q <= rend_d; rtot_q <= rtot_d; rlt_q <= rlt_d;
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    if (state_q == S_OUT && out_free) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      ok_q <= rk_q; os_q <= rst_q; otot_q <= rtot_q; oent_q <= rent_q; opid_q <= rpid_q;
      odep_q <= rdep_q; obeg_q <= rbeg_q; oend_q <= rend_q; oslot_q <= rslot_q;
      olt_q <= rlt_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.result_kind = ok_q;
  assign out_o.status      = os_q;
  assign out_o.joint_total = otot_q;
  assign out_o.entry_id    = oent_q;
  assign out_o.parent_id   = opid_q;
  assign out_o.depth       = odep_q;
  assign out_o.span_start  = obeg_q;
  assign out_o.span_stop   = oend_q;
  assign out_o.level_slot  = oslot_q;
  assign out_o.level_total = olt_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_RD || state_q == S_SCAN_EV || state_q == S_POP || state_q == S_FIN)
    |-> pos_q <= cnt_q)
    else $error("Preorder position ran past the joint count.");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= cnt_q)
    else $error("Walk stack grew past the joint count.");
  a_valid_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> closed_q)
    else $error("Valid layout without a closed batch.");
  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.command == tpb_pkg::CMD_LOAD && in_i.last_joint) |=> !in_i.ready)
    else $error("Word accepted while a build was starting.");

endmodule

[design/tree_preorder_builder.sv]
// A load is taken in S_IDLE; a read goes through S_RD2, S_RD3 and, for a joint with a parent, S_RD4 to S_OUT.
// The build after the last load walks the parent memory one entry at a time, with a read state and then
// an evaluate state per entry: once for the checks, once per joint for the child scans, then depth per level for slots.
// One word at a time: a read, a bad read or a last load holds the input until its result word is registered.
// Reset clears the joint count, the batch and the valid layout; build_levels resets to one.
// No clearing pass: every memory entry is written before it is read.
module tree_preorder_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tpb_in_if.sink      in_i,
  tpb_out_if.source   out_o
);

  logic build_levels;

  tpb_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .build_levels_o (build_levels)
  );

  tpb_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .build_levels_i (build_levels),
    .in_i           (in_i),
    .out_o          (out_o)
  );

endmodule

[sim/tb_tree_preorder_builder.sv]
// Testbench of the tree preorder builder: directed table, random forests, scoreboard.
module tb_tree_preorder_builder;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [8:0]  total;
    logic [31:0] eid;
    logic [31:0] pid;
    logic [7:0]  dep;
    logic [7:0]  sub_begin;
    logic [8:0]  sub_end;
    logic [7:0]  slot;
    logic [8:0]  levels;
  } answer_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] id;
    logic [9:0]  par;
    logic        last;
    logic [7:0]  pos;
  } word_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    answer_t ans;
  } row_t;

  localparam answer_t NOANS = '0;
  localparam int NROWS = 24;
  localparam row_t DIRECTED [NROWS] = '{
    '{'{tpb_pkg::CMD_READ, 32'h0, tpb_pkg::PARENT_NONE, 1'b0, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_READ, tpb_pkg::ST_BAD_POSITION, 9'd0, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'hFFFFFFFF, tpb_pkg::PARENT_NONE, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OK, 9'd1, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0, 8'd0, 9'd1}},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_READ, tpb_pkg::ST_OK, 9'd1, 32'hFFFFFFFF, 32'h0, 8'd0, 8'd0, 9'd1, 8'd0,
        9'd1}},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd255}, 1'b1,
      '{tpb_pkg::KIND_READ, tpb_pkg::ST_BAD_POSITION, 9'd1, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'h0, tpb_pkg::PARENT_NONE, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'h5, 10'h0, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'h7, 10'h1FF, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OUT_OF_RANGE, 9'd3, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_READ, tpb_pkg::ST_BAD_POSITION, 9'd3, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'h1, 10'h200, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OUT_OF_RANGE, 9'd1, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'h2, tpb_pkg::PARENT_NONE, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'h3, 10'h1, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OWN_PARENT, 9'd2, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'h4, 10'h1, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'h6, 10'h0, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_CYCLE, 9'd2, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0, 8'd0,
        9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'hA, tpb_pkg::PARENT_NONE, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'hB, 10'h2, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'hC, 10'h0, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'hD, tpb_pkg::PARENT_NONE, 1'b1, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd0}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd1}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd2}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd3}, 1'b0, NOANS},
    '{'{tpb_pkg::CMD_LOAD, 32'h55555555, 10'h2AA, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OUT_OF_RANGE, 9'd1, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_LOAD, 32'hAAAAAAAA, 10'h155, 1'b1, 8'd0}, 1'b1,
      '{tpb_pkg::KIND_BUILD, tpb_pkg::ST_OUT_OF_RANGE, 9'd1, 32'h0, 32'h0, 8'd0, 8'd0, 9'd0,
        8'd0, 9'd0}},
    '{'{tpb_pkg::CMD_READ, 32'h0, 10'h0, 1'b0, 8'd0}, 1'b0, NOANS}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tpb_in_if  in_ch ();
  tpb_out_if out_ch ();

  tree_preorder_builder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  answer_t pending_answers[$];
  int      error_count;
  int      words_sent;
  bit      idling_on;
  bit      hold_request;

  // Shadow of the block's layout state.
  logic [31:0] id_mem [tpb_pkg::MaxJoints];
  int          par_mem [tpb_pkg::MaxJoints];
  int          mark [tpb_pkg::MaxJoints];
  int          pre_of [tpb_pkg::MaxJoints];
  int          joint_at [tpb_pkg::MaxJoints];
  int          dep_mem [tpb_pkg::MaxJoints];
  int          end_mem [tpb_pkg::MaxJoints];
  int          slot_mem [tpb_pkg::MaxJoints];
  int          stk_joint [tpb_pkg::MaxJoints];
  int          stk_next [tpb_pkg::MaxJoints];
  int          load_cnt;
  bit          overflow;
  bit          batch_closed;
  bit          layout_valid;
  int          depth_levels;
  bit          levels_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void mark_visit(int j, int pos, int d);
    mark[j] = 1;
    pre_of[j] = pos;
    joint_at[pos] = j;
    dep_mem[pos] = d;
  endfunction

  function automatic logic [2:0] build_layout();
    int n, pos, maxd, sp, j, c, d, acc, cnt;
    int lvl [tpb_pkg::MaxJoints + 1];
    n = load_cnt;
    pos = 0;
    maxd = 0;
    if (overflow) return tpb_pkg::ST_TOO_MANY;
    for (int i = 0; i < n; i++) begin
      if (par_mem[i] < -1 || par_mem[i] >= n) return tpb_pkg::ST_OUT_OF_RANGE;
      if (par_mem[i] == i) return tpb_pkg::ST_OWN_PARENT;
    end
    for (int i = 0; i < tpb_pkg::MaxJoints; i++) mark[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (par_mem[i] != -1) continue;
      if (mark[i] != 0) return tpb_pkg::ST_CYCLE;
      mark_visit(i, pos, 0);
      pos++;
      stk_joint[0] = i;
      stk_next[0] = 0;
      sp = 1;
      while (sp > 0) begin
        j = stk_joint[sp-1];
        c = stk_next[sp-1];
        while (c < n && par_mem[c] != j) c++;
        if (c >= n) begin
          mark[j] = 2;
          end_mem[pre_of[j]] = pos;
          sp--;
          continue;
        end
        stk_next[sp-1] = c + 1;
        if (mark[c] != 0 || sp >= tpb_pkg::MaxJoints || pos >= tpb_pkg::MaxJoints)
          return tpb_pkg::ST_CYCLE;
        d = dep_mem[pre_of[j]] + 1;
        mark_visit(c, pos, d);
        if (d > maxd) maxd = d;
        pos++;
        stk_joint[sp] = c;
        stk_next[sp] = 0;
        sp++;
      end
    end
    for (int i = 0; i < n; i++) if (mark[i] == 0) return tpb_pkg::ST_CYCLE;
    depth_levels = 0;
    if (levels_on && n > 0) begin
      acc = 0;
      for (int i = 0; i <= tpb_pkg::MaxJoints; i++) lvl[i] = 0;
      for (int i = 0; i < n; i++) lvl[dep_mem[i]]++;
      for (d = 0; d <= maxd; d++) begin
        cnt = lvl[d];
        lvl[d] = acc;
        acc += cnt;
      end
      for (int i = 0; i < n; i++) begin
        slot_mem[i] = lvl[dep_mem[i]];
        lvl[dep_mem[i]]++;
      end
      depth_levels = maxd + 1;
    end else begin
      for (int i = 0; i < n; i++) slot_mem[i] = 0;
    end
    return tpb_pkg::ST_OK;
  endfunction

  function automatic bit predict_answer(word_t w, output answer_t a);
    int j, p;
    a = '0;
    if (w.cmd == tpb_pkg::CMD_LOAD) begin
      if (batch_closed) begin
        load_cnt = 0;
        overflow = 1'b0;
        layout_valid = 1'b0;
        batch_closed = 1'b0;
      end
      if (load_cnt < tpb_pkg::MaxJoints) begin
        id_mem[load_cnt] = w.id;
        par_mem[load_cnt] = int'($signed(w.par));
        load_cnt++;
      end else begin
        overflow = 1'b1;
      end
      if (!w.last) return 1'b0;
      batch_closed = 1'b1;
      a.kind = tpb_pkg::KIND_BUILD;
      a.status = build_layout();
      layout_valid = (a.status == tpb_pkg::ST_OK);
      a.total = 9'(load_cnt);
      a.levels = layout_valid ? 9'(depth_levels) : 9'd0;
      return 1'b1;
    end
    a.kind = tpb_pkg::KIND_READ;
    a.total = 9'(load_cnt);
    if (!layout_valid || int'(w.pos) >= load_cnt) begin
      a.status = tpb_pkg::ST_BAD_POSITION;
      return 1'b1;
    end
    j = joint_at[w.pos];
    p = par_mem[j];
    a.status = tpb_pkg::ST_OK;
    a.eid = id_mem[j];
    a.pid = (p >= 0) ? id_mem[p] : 32'h0;
    a.dep = 8'(dep_mem[w.pos]);
    a.sub_begin = w.pos;
    a.sub_end = 9'(end_mem[w.pos]);
    a.slot = 8'(slot_mem[w.pos]);
    a.levels = 9'(depth_levels);
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    error_count++;
  endtask

  task automatic send_word(word_t w, bit typed, answer_t typed_ans);
    answer_t a;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= w.cmd;
    in_ch.joint_id <= w.id;
    in_ch.parent_index <= w.par;
    in_ch.last_joint <= w.last;
    in_ch.read_position <= w.pos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
    if (predict_answer(w, a)) pending_answers = {pending_answers, (typed ? typed_ans : a)};
  endtask

  task automatic send_plain(word_t w);
    send_word(w, 1'b0, NOANS);
  endtask

  task automatic rest_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_levels(logic v);
    rest_input();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'({tpb_pkg::REG_BUILD_LEVELS, 2'b00});
    pwdata <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (!pready || prdata !== {31'b0, v}) report("build_levels", prdata, {31'b0, v});
    psel <= 1'b0;
    penable <= 1'b0;
    levels_on = v;
  endtask

  task automatic send_reads(int n, int cnt);
    word_t w;
    for (int k = 0; k < cnt; k++) begin
      w = '0;
      w.cmd = tpb_pkg::CMD_READ;
      w.id = $urandom();
      w.par = 10'($urandom());
      if ($urandom_range(0, 7) == 0) w.pos = 8'($urandom());
      else w.pos = 8'($urandom_range(0, (n > 0) ? n - 1 : 0));
      send_plain(w);
    end
  endtask

  // A random forest of n joints, or a chain when chain is set; broken batches get one parent replaced at random.
  task automatic send_forest(int n, bit broken, bit chain);
    int perm [tpb_pkg::MaxJoints + 1];
    int pars [tpb_pkg::MaxJoints + 1];
    int k, t, bad;
    word_t w;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[k];
      perm[k] = t;
    end
    for (int i = 0; i < n; i++) begin
      if (chain) pars[i] = i - 1;
      else if (i == 0 || $urandom_range(0, 3) == 0) pars[perm[i]] = -1;
      else pars[perm[i]] = perm[$urandom_range(0, i - 1)];
    end
    if (broken) begin
      bad = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0: pars[bad] = int'($signed(10'($urandom())));
        1: pars[bad] = bad;
        2: pars[bad] = n + $urandom_range(0, 3);
        default: pars[bad] = $urandom_range(0, n - 1);
      endcase
    end
    for (int i = 0; i < n; i++) begin
      w = '0;
      w.cmd = tpb_pkg::CMD_LOAD;
      w.id = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom();
      w.par = 10'(pars[i]);
      w.last = (i == n - 1);
      w.pos = 8'($urandom());
      send_plain(w);
    end
  endtask

  task automatic random_phase(int target);
    int n;
    word_t w;
    while (words_sent < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_forest(n, $urandom_range(0, 9) == 0, 1'b0);
      send_reads(n, $urandom_range(0, n + 3));
      if ($urandom_range(0, 11) == 0) begin
        w = '0;
        w.cmd = tpb_pkg::CMD_LOAD;
        w.id = $urandom();
        w.par = tpb_pkg::PARENT_NONE;
        send_plain(w);
        send_reads(2, 2);
        w.last = 1'b1;
        send_plain(w);
      end
    end
  endtask

  // Result side: checks each word and throttles ready.
  initial begin
    int burst;
    answer_t want, got;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_kind, out_ch.status, out_ch.joint_total, out_ch.entry_id,
                out_ch.parent_id, out_ch.depth, out_ch.span_start, out_ch.span_stop,
                out_ch.level_slot, out_ch.level_total};
        if (pending_answers.size() == 0) begin
          report("unexpected result word", 32'd1, 32'd0);
        end else begin
          want = pending_answers.pop_front();
          if (got.kind !== want.kind)
            report("result_kind", 32'(got.kind), 32'(want.kind));
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.total !== want.total)
            report("joint_total", 32'(got.total), 32'(want.total));
          if (got.eid !== want.eid) report("entry_id", got.eid, want.eid);
          if (got.pid !== want.pid) report("parent_id", got.pid, want.pid);
          if (got.dep !== want.dep) report("depth", 32'(got.dep), 32'(want.dep));
          if (got.sub_begin !== want.sub_begin)
            report("span start", 32'(got.sub_begin), 32'(want.sub_begin));
          if (got.sub_end !== want.sub_end)
            report("span stop", 32'(got.sub_end), 32'(want.sub_end));
          if (got.slot !== want.slot) report("level_slot", 32'(got.slot), 32'(want.slot));
          if (got.levels !== want.levels)
            report("level_total", 32'(got.levels), 32'(want.levels));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        burst = 400;
      end else if (burst == 0 && idling_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
      end
      if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20000000;
    $display("tree_preorder_builder test failed");
    $finish;
  end

  initial begin
    error_count = 0;
    words_sent = 0;
    idling_on = 1'b1;
    hold_request = 1'b0;
    load_cnt = 0;
    overflow = 1'b0;
    batch_closed = 1'b0;
    layout_valid = 1'b0;
    depth_levels = 0;
    levels_on = 1'b1;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = tpb_pkg::CMD_LOAD;
    in_ch.joint_id = '0;
    in_ch.parent_index = '0;
    in_ch.last_joint = 1'b0;
    in_ch.read_position = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NROWS; r++) send_word(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].ans);

    write_levels(1'b0);
    random_phase(300);

    write_levels(1'b1);
    hold_request = 1'b1;
    send_forest(6, 1'b0, 1'b0);
    send_reads(6, 24);
    send_forest(tpb_pkg::MaxJoints, 1'b0, 1'b1);
    send_reads(tpb_pkg::MaxJoints, 12);
    random_phase(600);

    write_levels(1'b0);
    send_forest(tpb_pkg::MaxJoints + 1, 1'b0, 1'b0);
    send_reads(4, 3);
    random_phase(850);

    write_levels(1'b1);
    idling_on = 1'b0;
    random_phase(1050);

    rest_input();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tree_preorder_builder test passed");
    end else begin
      $display("tree_preorder_builder test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/tpb_pkg.sv
design/tpb_if.sv
design/tpb_cfg.sv
design/tpb_engine.sv
design/tree_preorder_builder.sv
sim/tb_tree_preorder_builder.sv
